// File: src/npr_pkg.sv
// Shared types and constants for the nearest-point radius prune block.
package npr_pkg;

  localparam int RADIUS_W = 42;
  localparam int LIMIT_W  = 40;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 42'd13107;
  localparam logic [LIMIT_W-1:0]  DIST_LIMIT   = 40'd655359934464;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } npr_state_t;

endpackage

// File: src/nearest_point_radius_prune.sv
// Point store with radius-pruned nearest-point query, one shared distance pipeline.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | opcode, coord_x, coord_y, coord_z
//   out_    | output    | out_valid/out_stall| found, near_x/y/z, live_count, status
//   cfg_    | input     | cfg_wr_en          | cfg_wr_data (radius_threshold)
//
// Insert, clear and unused opcodes: result is registered on accept.
// Query: the scan covers the slots filled since the last clear, reading one slot per cycle
// from the store's single read port into a three-stage squared-distance pipeline, then
// the finish state removes the winner.
// Reset (rst_n low, synchronous) empties the store at once; no clearing pass.
// A new item is taken only when the block is idle and the result register is free
// or being taken.
module nearest_point_radius_prune import npr_pkg::*; #(
  parameter int STORE_DEPTH = 64,
  parameter int COORD_BITS  = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_opcode,
  input  logic signed [COORD_BITS-1:0]         in_coord_x,
  input  logic signed [COORD_BITS-1:0]         in_coord_y,
  input  logic signed [COORD_BITS-1:0]         in_coord_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_found,
  output logic signed [COORD_BITS-1:0]         out_near_x,
  output logic signed [COORD_BITS-1:0]         out_near_y,
  output logic signed [COORD_BITS-1:0]         out_near_z,
  output logic [$clog2(STORE_DEPTH+1)-1:0]     out_live_count,
  output logic                                 out_status,
  input  logic                                 cfg_wr_en,
  input  logic [RADIUS_W-1:0]                  cfg_wr_data
);

  localparam int IDX_W   = $clog2(STORE_DEPTH);
  localparam int CNT_W   = $clog2(STORE_DEPTH+1);
  localparam int ENTRY_W = 1 + 3*COORD_BITS;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ_W    = 2*DIFF_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int CMP_W   = (DIST_W > RADIUS_W) ? DIST_W : RADIUS_W;

  logic [ENTRY_W-1:0] mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  npr_state_t state_r, state_nxt;
  logic [RADIUS_W-1:0] radius_r;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;
  logic [CNT_W-1:0]    issue_r, issue_nxt;

  logic signed [COORD_BITS-1:0] cx_r, cy_r, cz_r;

  logic                 s1_valid_r;
  logic [IDX_W-1:0]     s1_idx_r;
  logic                 s2_valid_r;
  logic [IDX_W-1:0]     s2_idx_r;
  logic signed [DIFF_W-1:0] s2_dx_r, s2_dy_r, s2_dz_r;
  logic [3*COORD_BITS-1:0]  s2_pt_r;
  logic                 s3_valid_r;
  logic [IDX_W-1:0]     s3_idx_r;
  logic [SQ_W-1:0]      s3_sx_r, s3_sy_r, s3_sz_r;
  logic [3*COORD_BITS-1:0]  s3_pt_r;

  logic [CMP_W-1:0]        best_d_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic [3*COORD_BITS-1:0] best_pt_r;
  logic                    have_r;

  logic                 out_valid_r, out_found_r, out_status_r;
  logic [3*COORD_BITS-1:0] out_pt_r;
  logic [CNT_W-1:0]     out_live_r;

  logic accept, issue, pipe_empty, scan_done;
  logic [DIST_W-1:0] dist_sum;
  logic [CMP_W-1:0]  dist_c;
  logic del_hit, better;
  logic signed [SQ_W-1:0] px, py, pz;
  logic load_out;
  logic out_found_nxt, out_status_nxt;
  logic [3*COORD_BITS-1:0] out_pt_nxt;

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign issue    = (state_r == ST_SCAN) && (issue_r < fill_r);
  assign pipe_empty = !s1_valid_r && !s2_valid_r && !s3_valid_r;
  assign scan_done  = (state_r == ST_SCAN) && !issue && pipe_empty;

  assign dist_sum = DIST_W'(s3_sx_r) + DIST_W'(s3_sy_r) + DIST_W'(s3_sz_r);
  assign dist_c   = CMP_W'(dist_sum);
  assign del_hit  = s3_valid_r && (dist_c < CMP_W'(radius_r));
  assign better   = s3_valid_r && !del_hit && (dist_c < best_d_r);

  assign px = s2_dx_r * s2_dx_r;
  assign py = s2_dy_r * s2_dy_r;
  assign pz = s2_dz_r * s2_dz_r;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    live_nxt       = live_r;
    issue_nxt      = issue_r;
    wr_en          = 1'b0;
    wr_addr        = fill_r[IDX_W-1:0];
    wr_data        = {1'b1, in_coord_x, in_coord_y, in_coord_z};
    load_out       = 1'b0;
    out_found_nxt  = 1'b0;
    out_status_nxt = 1'b0;
    out_pt_nxt     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (in_opcode)
            OP_INSERT: begin
              if (fill_r == CNT_W'(STORE_DEPTH)) begin
                out_status_nxt = 1'b1;
              end else begin
                wr_en    = 1'b1;
                fill_nxt = fill_r + 1'b1;
                live_nxt = live_r + 1'b1;
              end
            end
            OP_QUERY: begin
              load_out  = 1'b0;
              issue_nxt = '0;
              state_nxt = ST_SCAN;
            end
            OP_CLEAR: begin
              fill_nxt = '0;
              live_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (del_hit) begin
          wr_en   = 1'b1;
          wr_addr = s3_idx_r;
          wr_data = {1'b0, s3_pt_r};
          if (live_r != '0) begin
            live_nxt = live_r - 1'b1;
          end
        end
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        load_out  = 1'b1;
        state_nxt = ST_IDLE;
        if (have_r) begin
          wr_en         = 1'b1;
          wr_addr       = best_idx_r;
          wr_data       = {1'b0, best_pt_r};
          out_found_nxt = 1'b1;
          out_pt_nxt    = best_pt_r;
          if (live_r != '0) begin
            live_nxt = live_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[issue_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= RADIUS_RESET;
      fill_r      <= '0;
      live_r      <= '0;
      issue_r     <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      live_r     <= live_nxt;
      issue_r    <= issue_nxt;
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r && rd_data_r[ENTRY_W-1];
      s3_valid_r <= s2_valid_r;
      if (accept) begin
        have_r <= 1'b0;
      end else if (better) begin
        have_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx_r     <= in_coord_x;
      cy_r     <= in_coord_y;
      cz_r     <= in_coord_z;
      best_d_r <= CMP_W'(DIST_LIMIT);
    end else if (better) begin
      best_d_r   <= dist_c;
      best_idx_r <= s3_idx_r;
      best_pt_r  <= s3_pt_r;
    end
    s1_idx_r <= issue_r[IDX_W-1:0];
    s2_idx_r <= s1_idx_r;
    s2_pt_r  <= rd_data_r[3*COORD_BITS-1:0];
    s2_dx_r  <= DIFF_W'($signed(rd_data_r[3*COORD_BITS-1:2*COORD_BITS])) - DIFF_W'(cx_r);
    s2_dy_r  <= DIFF_W'($signed(rd_data_r[2*COORD_BITS-1:COORD_BITS])) - DIFF_W'(cy_r);
    s2_dz_r  <= DIFF_W'($signed(rd_data_r[COORD_BITS-1:0])) - DIFF_W'(cz_r);
    s3_idx_r <= s2_idx_r;
    s3_pt_r  <= s2_pt_r;
    s3_sx_r  <= $unsigned(px);
    s3_sy_r  <= $unsigned(py);
    s3_sz_r  <= $unsigned(pz);
    if (load_out) begin
      out_found_r  <= out_found_nxt;
      out_status_r <= out_status_nxt;
      out_pt_r     <= out_pt_nxt;
      out_live_r   <= live_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_status     = out_status_r;
  assign out_near_x     = out_pt_r[3*COORD_BITS-1:2*COORD_BITS];
  assign out_near_y     = out_pt_r[2*COORD_BITS-1:COORD_BITS];
  assign out_near_z     = out_pt_r[COORD_BITS-1:0];
  assign out_live_count = out_live_r;

endmodule

// File: src/npr_checker.sv
// Port-level checks for the nearest-point radius prune block, bound to the top level.
module npr_props import npr_pkg::*; #(
  parameter int STORE_DEPTH = 64,
  parameter int COORD_BITS  = 20
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_found,
  input logic signed [COORD_BITS-1:0]     out_near_x,
  input logic signed [COORD_BITS-1:0]     out_near_y,
  input logic signed [COORD_BITS-1:0]     out_near_z,
  input logic [$clog2(STORE_DEPTH+1)-1:0] out_live_count,
  input logic                             out_status
);

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_live_count)))
    else $error("stalled result dropped or changed");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("item taken while result register blocked");

  a_found_excludes_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> !out_status)
    else $error("found and refused together");

  a_zero_when_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_near_x == '0 && out_near_y == '0 && out_near_z == '0))
    else $error("near point not zero without a find");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_live_count <= STORE_DEPTH))
    else $error("live count beyond store depth");

endmodule

bind nearest_point_radius_prune npr_props #(
  .STORE_DEPTH(STORE_DEPTH),
  .COORD_BITS (COORD_BITS)
) u_npr_props (.*);
